// ===== src/trm_pkg.sv =====
package trm_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_IN   = 5'd1;
    localparam logic [4:0] OP_OUT  = 5'd2;
    localparam logic [4:0] OP_ADD  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_MUL  = 5'd5;
    localparam logic [4:0] OP_DIV  = 5'd6;
    localparam logic [4:0] OP_RLAST = 5'd7;
    localparam logic [4:0] OP_LD   = 5'd8;
    localparam logic [4:0] OP_ST   = 5'd9;
    localparam logic [4:0] OP_MLAST = 5'd10;
    localparam logic [4:0] OP_LDA  = 5'd11;
    localparam logic [4:0] OP_LDC  = 5'd12;
    localparam logic [4:0] OP_JLT  = 5'd13;
    localparam logic [4:0] OP_JLE  = 5'd14;
    localparam logic [4:0] OP_JGT  = 5'd15;
    localparam logic [4:0] OP_JGE  = 5'd16;
    localparam logic [4:0] OP_JEQ  = 5'd17;
    localparam logic [4:0] OP_JNE  = 5'd18;

    localparam logic [2:0] STAT_OK   = 3'd0;
    localparam logic [2:0] STAT_HALT = 3'd1;
    localparam logic [2:0] STAT_IMEM = 3'd2;
    localparam logic [2:0] STAT_DMEM = 3'd3;
    localparam logic [2:0] STAT_DIV0 = 3'd4;

    localparam logic [2:0] PC_IDX = 3'd7;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_DISP,
        S_SER,
        S_MUL,
        S_DIV,
        S_FIX,
        S_CHK,
        S_WB,
        S_DONE
    } state_t;

endpackage

// ===== src/tiny_register_machine_step_top.sv =====
// Executes one instruction of the eight-register teaching machine per beat.
// The slave channel carries the instruction fetched at the address that the
// last result reported as next_pc, plus the value for an IN instruction.
// The master channel returns one result beat per instruction: status, the
// new program counter and the OUT and IN flags.
// HALT, IN, OUT and a zero divisor go from dispatch straight to write-back.
// ADD, SUB, memory, address, constant and jump instructions go through a
// bit-serial adder one bit per cycle; MUL and DIV iterate one bit per cycle
// over a shared 32-bit shift datapath.
// The next beat is accepted from the cycle after the result register loads.
// A fetch at a program counter outside the instruction store goes straight
// to write-back and returns with nothing changed.
// After reset the data memory is cleared one word per cycle and word 0 is
// set to DATA_DEPTH-1; no beat is accepted during that pass. The register
// file clears at once.
// When the receiver stalls, the result waits in the output register and the
// next instruction is accepted and executed, holding its own result until
// the output register is free.
module tiny_register_machine_step_top
    import trm_pkg::*;
#(
    parameter int DATA_DEPTH  = 1024,
    parameter int INSTR_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[4:0], dest_reg[7:5], mid_arg[39:8], last_reg[42:40], in_value[74:43]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], next_pc[34:3], out_valid[35], out_value[67:36], in_used[68]
    output logic [71:0] m_tdata
);

    localparam int AW = $clog2(DATA_DEPTH);

    state_t state_reg, state_next;

    logic [WORD_W-1:0] rf_reg [8];
    logic [4:0]        op_reg;
    logic [2:0]        r_reg, t_reg;
    logic [WORD_W-1:0] arg_reg, inval_reg;
    logic [WORD_W-1:0] a_reg, b_reg, v_reg, res_reg, rem_reg;
    logic              carry_reg, sub_reg, neg_reg;
    logic [2:0]        status_reg;
    logic [4:0]        bit_cnt_reg;
    logic [AW-1:0]     clr_cnt_reg;

    logic              m_tvalid_reg;
    logic [2:0]        o_status_reg;
    logic [WORD_W-1:0] o_pc_reg, o_outv_reg;
    logic              o_outvalid_reg, o_inused_reg;

    logic [2:0]        rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic              ybit, sbit;
    logic [WORD_W:0]   rem_sh, diff;
    logic              take;
    logic              v_neg, v_zero;
    logic              wb_ok;

    assign rd_data = rf_reg[rd_addr];
    assign ybit    = b_reg[0] ^ sub_reg;
    assign sbit    = a_reg[0] ^ ybit ^ carry_reg;
    assign rem_sh  = {rem_reg, a_reg[WORD_W-1]};
    assign diff    = rem_sh - {1'b0, b_reg};
    assign v_neg   = v_reg[WORD_W-1];
    assign v_zero  = (v_reg == '0);
    assign wb_ok   = (status_reg == STAT_OK);

    always_comb begin
        case (op_reg)
            OP_JLT:  take = v_neg;
            OP_JLE:  take = v_neg || v_zero;
            OP_JGT:  take = !v_neg && !v_zero;
            OP_JGE:  take = !v_neg;
            OP_JEQ:  take = v_zero;
            OP_JNE:  take = !v_zero;
            default: take = 1'b0;
        endcase
    end

    trm_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DATA_DEPTH)
    ) u_dmem (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(res_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == AW'(DATA_DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    if (rf_reg[PC_IDX] >= WORD_W'(INSTR_DEPTH)) state_next = S_WB;
                    else state_next = S_RD0;
                end
            end
            S_RD0: state_next = S_RD1;
            S_RD1: state_next = S_RD2;
            S_RD2: state_next = S_DISP;
            S_DISP: begin
                if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg > OP_RLAST) begin
                    state_next = S_SER;
                end else if (op_reg == OP_MUL) begin
                    state_next = S_MUL;
                end else if (op_reg == OP_DIV && b_reg != '0) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_WB;
                end
            end
            S_SER: begin
                if (bit_cnt_reg == 5'd31) state_next = S_CHK;
            end
            S_MUL: begin
                if (bit_cnt_reg == 5'd31) state_next = S_WB;
            end
            S_DIV: begin
                if (bit_cnt_reg == 5'd31) state_next = S_FIX;
            end
            S_FIX:  state_next = S_WB;
            S_CHK:  state_next = S_WB;
            S_WB:   state_next = S_DONE;
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        rd_addr   = r_reg;
        ram_we    = 1'b0;
        ram_waddr = res_reg[AW-1:0];
        ram_wdata = v_reg;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = (clr_cnt_reg == '0) ? WORD_W'(DATA_DEPTH - 1) : '0;
            end
            S_RD0: rd_addr = arg_reg[2:0];
            S_RD1: rd_addr = t_reg;
            S_WB: begin
                ram_we = wb_ok && (op_reg == OP_ST);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            bit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                rf_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: clr_cnt_reg <= clr_cnt_reg + 1'b1;
                S_IDLE: begin
                    op_reg     <= s_tdata[4:0];
                    r_reg      <= s_tdata[7:5];
                    arg_reg    <= s_tdata[39:8];
                    t_reg      <= s_tdata[42:40];
                    inval_reg  <= s_tdata[74:43];
                    status_reg <= STAT_OK;
                    if (s_tvalid) begin
                        if (rf_reg[PC_IDX] >= WORD_W'(INSTR_DEPTH)) begin
                            status_reg <= STAT_IMEM;
                        end else begin
                            rf_reg[PC_IDX] <= rf_reg[PC_IDX] + 1'b1;
                        end
                    end
                end
                S_RD0: a_reg <= rd_data;
                S_RD1: b_reg <= rd_data;
                S_RD2: v_reg <= rd_data;
                S_DISP: begin
                    bit_cnt_reg <= '0;
                    carry_reg   <= (op_reg == OP_SUB);
                    sub_reg     <= (op_reg == OP_SUB);
                    res_reg     <= '0;
                    rem_reg     <= '0;
                    neg_reg     <= a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
                    case (op_reg)
                        OP_HALT: status_reg <= STAT_HALT;
                        OP_DIV: begin
                            if (b_reg == '0) status_reg <= STAT_DIV0;
                            if (a_reg[WORD_W-1]) a_reg <= '0 - a_reg;
                            if (b_reg[WORD_W-1]) b_reg <= '0 - b_reg;
                        end
                        default: begin
                            if (op_reg > OP_RLAST) a_reg <= arg_reg;
                        end
                    endcase
                end
                S_SER: begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    res_reg     <= {sbit, res_reg[WORD_W-1:1]};
                    carry_reg   <= (a_reg[0] & ybit) | (a_reg[0] & carry_reg)
                                 | (ybit & carry_reg);
                    a_reg       <= a_reg >> 1;
                    b_reg       <= b_reg >> 1;
                end
                S_MUL: begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (b_reg[0]) res_reg <= res_reg + a_reg;
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
                S_DIV: begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (!diff[WORD_W]) begin
                        rem_reg <= diff[WORD_W-1:0];
                        a_reg   <= {a_reg[WORD_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[WORD_W-1:0];
                        a_reg   <= {a_reg[WORD_W-2:0], 1'b0};
                    end
                end
                S_FIX: res_reg <= neg_reg ? ('0 - a_reg) : a_reg;
                S_CHK: begin
                    if (op_reg > OP_RLAST && op_reg <= OP_MLAST
                            && res_reg >= WORD_W'(DATA_DEPTH)) begin
                        status_reg <= STAT_DMEM;
                    end
                end
                S_WB: begin
                    if (wb_ok) begin
                        case (op_reg)
                            OP_IN: rf_reg[r_reg] <= inval_reg;
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LDA: begin
                                rf_reg[r_reg] <= res_reg;
                            end
                            OP_LD:  rf_reg[r_reg] <= ram_rdata;
                            OP_LDC: rf_reg[r_reg] <= arg_reg;
                            default: begin
                                if (take) rf_reg[PC_IDX] <= res_reg;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg   <= 1'b1;
                        o_status_reg   <= status_reg;
                        o_pc_reg       <= rf_reg[PC_IDX];
                        o_outvalid_reg <= wb_ok && (op_reg == OP_OUT);
                        o_outv_reg     <= (wb_ok && op_reg == OP_OUT) ? v_reg : '0;
                        o_inused_reg   <= wb_ok && (op_reg == OP_IN);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, o_inused_reg, o_outv_reg, o_outvalid_reg, o_pc_reg,
                       o_status_reg};

endmodule

// ===== src/trm_ram.sv =====
module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
